FILE: hdl/tlb_lru_address_translator_unit_defines.svh
// Assertion macros for the TLB address translator checker.
// Depends on nothing; included by the checker file.
`ifndef TLB_LRU_ADDRESS_TRANSLATOR_UNIT_DEFINES_SVH
`define TLB_LRU_ADDRESS_TRANSLATOR_UNIT_DEFINES_SVH

// Same-cycle implication under synchronous active-low reset.
`define TLB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlb_lru: same-cycle check failed");

// Next-cycle implication under synchronous active-low reset.
`define TLB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlb_lru: next-cycle check failed");

`endif

FILE: hdl/tlb_lru_pkg.sv
// Shared sizes, types and sequencer states of the TLB address translator.
// No dependencies.
package tlb_lru_pkg;

  localparam int TLB_ENTRIES = 4;
  localparam int PAGE_COUNT  = 256;
  localparam int OFFSET_BITS = 8;

  localparam int VA_W    = 16;
  localparam int PA_W    = 16;
  localparam int PAGE_OW = 8;   // width of the page tag / page_number field
  localparam int FRAME_W = 8;
  localparam int NFF_W   = 9;

  localparam int PAGE_W = $clog2(PAGE_COUNT);
  localparam int IDX_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_TABLE,
    ST_WAIT,
    ST_TOUCH,
    ST_EMIT
  } state_t;

endpackage

FILE: hdl/tlb_lru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlb_lru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/tlb_lru_address_translator_unit.sv
// Address translator: 4-entry fully associative TLB with LRU refill, backed
// by a demand-filled page table. Depends on tlb_lru_pkg and tlb_lru_ram.
//
// One virtual address comes in per beat and one result beat goes out. The
// TLB is searched one entry per cycle through a single tag comparator; the
// same scan picks the refill victim (lowest invalid entry, else highest
// LRU rank). On a miss the page table is consulted: mapped pages are read
// from the frame RAM (registered read), unmapped pages get the
// next free frame written in. The states run in order: the serial TLB scan
// until a hit or the last entry; on a miss the page-table lookup, with a wait
// state for the RAM read of a mapped page; then the LRU touch and, on a miss,
// the TLB refill; then the output register load. in_stall is high for the
// whole time an item is in work; a finished result sits in the output
// register until taken, and the next item may be accepted while it waits.
// TLB and page-table valid bits and LRU ranks are set by reset directly; no
// clearing pass is needed.
module tlb_lru_address_translator_unit
  import tlb_lru_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VA_W-1:0]    in_virtual_address,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PA_W-1:0]    out_physical_address,
  output logic [PAGE_OW-1:0] out_page_number,
  output logic [FRAME_W-1:0] out_frame_number,
  output logic               out_tlb_hit,
  output logic               out_new_mapping
);

  // sequencer and working registers
  state_t             state_r, state_nxt;
  logic [VA_W-1:0]    va_r, va_nxt;
  idx_t               idx_r, idx_nxt;     // scan position
  idx_t               kidx_r, kidx_nxt;   // hit entry or refill victim
  idx_t               krank_r, krank_nxt; // its LRU rank
  logic               have_inv_r, have_inv_nxt;
  logic               hit_r, hit_nxt;
  logic               fresh_r, fresh_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [NFF_W-1:0]   nff_r, nff_nxt;

  // TLB entries and LRU ranks (0 = most recent)
  logic               tlb_valid_r [TLB_ENTRIES];
  logic [PAGE_OW-1:0] tlb_page_r  [TLB_ENTRIES];
  logic [FRAME_W-1:0] tlb_frame_r [TLB_ENTRIES];
  idx_t               lru_rank_r  [TLB_ENTRIES];

  // page-table valid bits; frames live in the RAM
  logic               table_valid_r [PAGE_COUNT];

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [PA_W-1:0]    out_pa_r, out_pa_nxt;
  logic [PAGE_OW-1:0] out_page_r, out_page_nxt;
  logic [FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic               out_fresh_r, out_fresh_nxt;

  // strobes
  logic               tlb_we, touch_en, tv_set, ram_we, ram_re;
  logic [FRAME_W-1:0] ram_rdata;

  // address split
  logic [VA_W-1:0]    va_shift;
  logic [PAGE_W-1:0]  page_idx;
  logic [VA_W-1:0]    page_ext;
  logic [PAGE_OW-1:0] page_b;
  logic               tag_match;
  logic               scan_last;

  assign va_shift  = va_r >> OFFSET_BITS;
  assign page_idx  = va_shift[PAGE_W-1:0];
  assign page_ext  = VA_W'(page_idx);
  assign page_b    = page_ext[PAGE_OW-1:0];
  // the one shared comparator: tag of the entry under the scan pointer
  assign tag_match = tlb_valid_r[idx_r] && (tlb_page_r[idx_r] == page_b);
  assign scan_last = (idx_r == IDX_W'(TLB_ENTRIES - 1));

  tlb_lru_ram #(
    .WIDTH(FRAME_W),
    .DEPTH(PAGE_COUNT)
  ) u_frame_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(page_idx),
    .wdata(nff_r[FRAME_W-1:0]),
    .re   (ram_re),
    .raddr(page_idx),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    va_nxt        = va_r;
    idx_nxt       = idx_r;
    kidx_nxt      = kidx_r;
    krank_nxt     = krank_r;
    have_inv_nxt  = have_inv_r;
    hit_nxt       = hit_r;
    fresh_nxt     = fresh_r;
    frame_nxt     = frame_r;
    nff_nxt       = nff_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pa_nxt    = out_pa_r;
    out_page_nxt  = out_page_r;
    out_frame_nxt = out_frame_r;
    out_hit_nxt   = out_hit_r;
    out_fresh_nxt = out_fresh_r;
    tlb_we        = 1'b0;
    touch_en      = 1'b0;
    tv_set        = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          va_nxt       = in_virtual_address;
          idx_nxt      = '0;
          have_inv_nxt = 1'b0;
          hit_nxt      = 1'b0;
          fresh_nxt    = 1'b0;
          state_nxt    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tag_match) begin
          hit_nxt   = 1'b1;
          kidx_nxt  = idx_r;
          krank_nxt = lru_rank_r[idx_r];
          frame_nxt = tlb_frame_r[idx_r];
          state_nxt = ST_TOUCH;
        end else begin
          // victim tracking: lowest invalid wins, else oldest rank
          if (!have_inv_r) begin
            if (!tlb_valid_r[idx_r]) begin
              have_inv_nxt = 1'b1;
              kidx_nxt     = idx_r;
              krank_nxt    = lru_rank_r[idx_r];
            end else if ((idx_r == '0) || (lru_rank_r[idx_r] > krank_r)) begin
              kidx_nxt  = idx_r;
              krank_nxt = lru_rank_r[idx_r];
            end
          end
          if (scan_last) begin
            state_nxt = ST_TABLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_TABLE: begin
        if (table_valid_r[page_idx]) begin
          ram_re    = 1'b1;
          state_nxt = ST_WAIT;
        end else begin
          ram_we    = 1'b1;
          tv_set    = 1'b1;
          fresh_nxt = 1'b1;
          frame_nxt = nff_r[FRAME_W-1:0];
          nff_nxt   = nff_r + 1'b1;
          state_nxt = ST_TOUCH;
        end
      end
      ST_WAIT: begin
        frame_nxt = ram_rdata;
        state_nxt = ST_TOUCH;
      end
      ST_TOUCH: begin
        touch_en  = 1'b1;
        tlb_we    = !hit_r;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_pa_nxt    = PA_W'({frame_r, va_r[OFFSET_BITS-1:0]});
          out_page_nxt  = page_b;
          out_frame_nxt = frame_r;
          out_hit_nxt   = hit_r;
          out_fresh_nxt = fresh_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      nff_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      nff_r       <= nff_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    va_r        <= va_nxt;
    idx_r       <= idx_nxt;
    kidx_r      <= kidx_nxt;
    krank_r     <= krank_nxt;
    have_inv_r  <= have_inv_nxt;
    hit_r       <= hit_nxt;
    fresh_r     <= fresh_nxt;
    frame_r     <= frame_nxt;
    out_pa_r    <= out_pa_nxt;
    out_page_r  <= out_page_nxt;
    out_frame_r <= out_frame_nxt;
    out_hit_r   <= out_hit_nxt;
    out_fresh_r <= out_fresh_nxt;
  end

  // TLB valid bits and LRU ranks; refill and touch happen together
  always_ff @(posedge clk) begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!rst_n) begin
        tlb_valid_r[i] <= 1'b0;
        lru_rank_r[i]  <= IDX_W'(i);
      end else begin
        if (tlb_we && (kidx_r == IDX_W'(i))) begin
          tlb_valid_r[i] <= 1'b1;
        end
        if (touch_en) begin
          if (kidx_r == IDX_W'(i)) begin
            lru_rank_r[i] <= '0;
          end else if (lru_rank_r[i] < krank_r) begin
            lru_rank_r[i] <= lru_rank_r[i] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (tlb_we && (kidx_r == IDX_W'(i))) begin
        tlb_page_r[i]  <= page_b;
        tlb_frame_r[i] <= frame_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < PAGE_COUNT; p++) begin
      if (!rst_n) begin
        table_valid_r[p] <= 1'b0;
      end else if (tv_set && (page_idx == PAGE_W'(p))) begin
        table_valid_r[p] <= 1'b1;
      end
    end
  end

  assign in_stall             = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_physical_address = out_pa_r;
  assign out_page_number      = out_page_r;
  assign out_frame_number     = out_frame_r;
  assign out_tlb_hit          = out_hit_r;
  assign out_new_mapping      = out_fresh_r;

endmodule

FILE: hdl/tlb_lru_checker.sv
// Port-level checks for the TLB address translator, bound to the translator unit.
// Depends on tlb_lru_pkg and tlb_lru_address_translator_unit_defines.svh.
`include "tlb_lru_address_translator_unit_defines.svh"

module tlb_lru_checker
  import tlb_lru_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [VA_W-1:0]    in_virtual_address,
  input logic               out_valid,
  input logic               out_stall,
  input logic [PA_W-1:0]    out_physical_address,
  input logic [PAGE_OW-1:0] out_page_number,
  input logic [FRAME_W-1:0] out_frame_number,
  input logic               out_tlb_hit,
  input logic               out_new_mapping
);

  // a TLB hit never hands out a fresh frame
  `TLB_ASSERT_IMP(a_hit_not_fresh, clk, rst_n, out_valid && out_tlb_hit, !out_new_mapping)

  // one item in work at a time: busy right after an accepted beat
  `TLB_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // a result cannot appear in the cycle right after its input was taken
  `TLB_ASSERT_NXT(a_no_instant_result, clk, rst_n, in_valid && !in_stall && !out_valid, !out_valid)

  // stalled result beat holds
  `TLB_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_physical_address) && $stable(out_frame_number))

endmodule

bind tlb_lru_address_translator_unit tlb_lru_checker u_tlb_lru_checker (.*);

FILE: bench/tb_top.sv
// Self-checking bench for tlb_lru_address_translator_unit: a scoreboard keeps
// its own TLB, LRU ranks and page table and checks every translated beat.
// Depends on tlb_lru_pkg and the translator RTL.
module tb_top;
  import tlb_lru_pkg::*;

  localparam int ITEM_COUNT   = 1050;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 24;    // well past the longest miss interval
  localparam int REPORT_MAX   = 10;
  localparam int HOT_SLOTS    = 6;

  // One translation as it leaves the block.
  typedef struct packed {
    logic [PA_W-1:0]    phys;
    logic [PAGE_OW-1:0] page;
    logic [FRAME_W-1:0] frame;
    logic               hit;
    logic               fresh;
  } xlat_t;

  // Shadow translator plus the queue of translations still owed by the block.
  class translation_scoreboard;
    logic               entry_valid [TLB_ENTRIES];
    logic [PAGE_OW-1:0] entry_page  [TLB_ENTRIES];
    logic [FRAME_W-1:0] entry_frame [TLB_ENTRIES];
    idx_t               entry_rank  [TLB_ENTRIES];
    logic               map_valid   [PAGE_COUNT];
    logic [FRAME_W-1:0] map_frame   [PAGE_COUNT];
    logic [NFF_W-1:0]   frame_cursor;
    xlat_t              awaited[$];
    int                 failures;
    int                 reported;

    function new();
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        entry_valid[i] = 1'b0;
        entry_page[i]  = '0;
        entry_frame[i] = '0;
        entry_rank[i]  = idx_t'(i);
      end
      for (int p = 0; p < PAGE_COUNT; p++) begin
        map_valid[p] = 1'b0;
        map_frame[p] = '0;
      end
      frame_cursor = '0;
      failures     = 0;
      reported     = 0;
    endfunction

    // Entry k becomes most recent; the ones that were more recent age by one.
    function void promote(int k);
      idx_t old_rank;
      old_rank = entry_rank[k];
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (entry_rank[i] < old_rank) entry_rank[i] = entry_rank[i] + 1'b1;
      end
      entry_rank[k] = '0;
    endfunction

    function void note_address(logic [VA_W-1:0] va);
      xlat_t x;
      int    page_idx;
      int    slot;
      int    victim;
      x        = '0;
      page_idx = (int'(va) >> OFFSET_BITS) % PAGE_COUNT;
      x.page   = PAGE_OW'(page_idx);
      slot     = -1;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (slot < 0 && entry_valid[i] && entry_page[i] == x.page) slot = i;
      end
      if (slot >= 0) begin
        x.hit   = 1'b1;
        x.frame = entry_frame[slot];
        promote(slot);
      end else begin
        if (!map_valid[page_idx]) begin
          map_frame[page_idx] = frame_cursor[FRAME_W-1:0];
          map_valid[page_idx] = 1'b1;
          frame_cursor        = frame_cursor + 1'b1;
          x.fresh             = 1'b1;
        end
        x.frame = map_frame[page_idx];
        // refill: lowest invalid entry, else the one with the highest rank
        victim = 0;
        for (int i = 1; i < TLB_ENTRIES; i++) begin
          if (entry_rank[i] > entry_rank[victim]) victim = i;
        end
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
          if (!entry_valid[i]) victim = i;
        end
        entry_valid[victim] = 1'b1;
        entry_page[victim]  = x.page;
        entry_frame[victim] = x.frame;
        promote(victim);
      end
      x.phys = PA_W'((int'(x.frame) << OFFSET_BITS) +
                     (int'(va) & ((1 << OFFSET_BITS) - 1)));
      awaited.push_back(x);
    endfunction

    function void check_result(xlat_t got);
      xlat_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (reported < REPORT_MAX) begin
          reported++;
          $display("unexpected result beat: pa=%h page=%h frame=%h hit=%b new=%b",
                   got.phys, got.page, got.frame, got.hit, got.fresh);
        end
        return;
      end
      want = awaited.pop_front();
      if (got.phys !== want.phys || got.page !== want.page || got.frame !== want.frame ||
          got.hit !== want.hit || got.fresh !== want.fresh) begin
        failures++;
        if (reported < REPORT_MAX) begin
          reported++;
          $display("mismatch: want pa=%h page=%h frame=%h hit=%b new=%b",
                   want.phys, want.page, want.frame, want.hit, want.fresh);
          $display("          got  pa=%h page=%h frame=%h hit=%b new=%b",
                   got.phys, got.page, got.frame, got.hit, got.fresh);
        end
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n              = 1'b0;
  logic              in_valid           = 1'b0;
  logic              in_stall;
  logic [VA_W-1:0]   in_virtual_address = '0;
  logic              out_valid;
  logic              out_stall          = 1'b0;
  logic [PA_W-1:0]    out_physical_address;
  logic [PAGE_OW-1:0] out_page_number;
  logic [FRAME_W-1:0] out_frame_number;
  logic               out_tlb_hit;
  logic               out_new_mapping;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_cycles    = 0;

  translation_scoreboard sb = new();

  // Directed opening: offset extremes, first fill of all four entries, a hit on
  // every entry, LRU evictions, refills of pages already in the page table,
  // and alternating bit patterns.
  localparam logic [VA_W-1:0] DIRECTED [18] = '{
    16'h0000, 16'h00FF,              // page 0 miss (frame 0), then hit
    16'hFFFF, 16'hFF00,              // top page miss, then hit
    16'h0180, 16'h02AA,              // TLB now full
    16'h0055, 16'hFF11, 16'h0122, 16'h0233,  // hit each entry in turn
    16'h0344,                        // new page, evicts page 0 (oldest)
    16'h0066,                        // page 0 again: table hit, evicts top page
    16'hFF77,                        // top page from the table, evicts page 1
    16'h0399,                        // hit on the fresh entry
    16'hAA5A, 16'h55A5, 16'h8001, 16'h7FFE
  };

  tlb_lru_address_translator_unit DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_virtual_address   (in_virtual_address),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_physical_address (out_physical_address),
    .out_page_number      (out_page_number),
    .out_frame_number     (out_frame_number),
    .out_tlb_hit          (out_tlb_hit),
    .out_new_mapping      (out_new_mapping)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Beat monitor: values sampled here are the ones the DUT saw at this edge.
  // Results are checked before the new address is noted; a result can never
  // belong to an address taken in the same cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result({out_physical_address, out_page_number, out_frame_number,
                         out_tlb_hit, out_new_mapping});
      end
      if (in_valid && !in_stall) sb.note_address(in_virtual_address);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: the bench is stuck, and fails, once idle_cycles reaches IDLE_LIMIT.
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // One address beat, with random idle cycles ahead of it. Returns at the edge
  // that takes the beat; valid stays high if the caller sends another.
  task automatic send_address(input logic [VA_W-1:0] va);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_virtual_address <= va;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // One edge first, so the beat taken at the current edge is already noted.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    logic [PAGE_OW-1:0] hot_pages [HOT_SLOTS];
    logic [PAGE_OW-1:0] page;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase 1: sender rarely idles, receiver stalls about half the time
    send_idle_pct  = 6;
    recv_stall_pct <= 47;
    foreach (DIRECTED[i]) send_address(DIRECTED[i]);

    // hold the sender until every owed translation has come back
    wait_drained();

    // Random part: mostly a small hot set of pages so the TLB hits and the
    // LRU order churns, the rest spread over the whole page range.
    foreach (hot_pages[i]) hot_pages[i] = PAGE_OW'($urandom_range(255));
    for (int n = 0; n < ITEM_COUNT; n++) begin
      if (n == ITEM_COUNT / 3) begin
        send_idle_pct  = 47;
        recv_stall_pct <= 6;
      end else if (n == 2 * ITEM_COUNT / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct <= 0;
      end
      if ($urandom_range(99) < 5)
        hot_pages[$urandom_range(HOT_SLOTS - 1)] = PAGE_OW'($urandom_range(255));
      if ($urandom_range(99) < 65) page = hot_pages[$urandom_range(HOT_SLOTS - 1)];
      else page = PAGE_OW'($urandom_range(255));
      send_address({page, 8'($urandom_range(255))});
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/tlb_lru_pkg.sv
hdl/tlb_lru_ram.sv
hdl/tlb_lru_address_translator_unit.sv
hdl/tlb_lru_checker.sv
bench/tb_top.sv
